### sv/ght_pkg.sv
package ght_pkg;

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_FREE    = 3'd1,
    OP_QUERY   = 3'd2,
    OP_ACT     = 3'd3,
    OP_DEACT   = 3'd4,
    OP_SET_IDX = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_STALE = 2'd2;
  localparam logic [1:0] ST_NEVER = 2'd3;

  localparam int SLOT_W = 10;
  localparam int GEN_W  = 16;
  localparam int TYPE_W = 15;
  localparam int IDX_W  = 32;

  localparam logic [IDX_W-1:0] LINK_END = '1;

  typedef struct packed {
    logic [GEN_W-1:0]  gen;
    logic              act;
    logic [TYPE_W-1:0] ty;
    logic [IDX_W-1:0]  idx;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

endpackage

### sv/ght_ctrl.sv
module ght_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output ght_pkg::cmd_t     cmd
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;

  assign busy        = (state == EXEC);
  assign cmd.capture = (state == IDLE) && start;
  assign cmd.exec    = (state == EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == EXEC);
      unique case (state)
        IDLE: begin
          if (start) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### sv/ght_dp.sv
module ght_dp #(
  parameter int SLOTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ght_pkg::cmd_t               cmd,
  input  logic [2:0]                  op,
  input  logic [ght_pkg::SLOT_W-1:0]  slot,
  input  logic [ght_pkg::GEN_W-1:0]   generation,
  input  logic [ght_pkg::TYPE_W-1:0]  type_tag,
  input  logic [ght_pkg::IDX_W-1:0]   entry_index,
  output logic [1:0]                  status,
  output logic [ght_pkg::SLOT_W-1:0]  slot_out,
  output logic [ght_pkg::GEN_W-1:0]   generation_out,
  output logic [ght_pkg::TYPE_W-1:0]  type_out,
  output logic [ght_pkg::IDX_W-1:0]   index_out,
  output logic                        active_out,
  output logic                        valid_res
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = SW + 1;
  localparam int XW = (CW > ght_pkg::SLOT_W) ? CW : ght_pkg::SLOT_W;

  ght_pkg::entry_t mem [SLOTS];
  ght_pkg::entry_t rd_data;

  // captured item
  logic [2:0]                  op_q;
  logic [ght_pkg::SLOT_W-1:0]  slot_q;
  logic [ght_pkg::GEN_W-1:0]   gen_q;
  logic [ght_pkg::TYPE_W-1:0]  type_q;
  logic [ght_pkg::IDX_W-1:0]   uidx_q;

  logic [CW-1:0] free_head;
  logic [CW-1:0] free_head_next;
  logic [CW-1:0] fresh_count;
  logic [CW-1:0] fresh_count_next;

  logic [XW-1:0] slot_in_x;
  logic [XW-1:0] slot_x;
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] slot_idx;
  logic          head_ok;
  logic          fresh_ok;
  logic [SW-1:0] alloc_slot;
  logic [XW-1:0] alloc_x;

  logic            wr_en;
  logic [SW-1:0]   wr_addr;
  ght_pkg::entry_t wr_data;

  logic [1:0]                  r_status;
  logic [ght_pkg::SLOT_W-1:0]  r_slot;
  ght_pkg::entry_t             r_entry;
  logic                        r_valid;

  assign slot_in_x = XW'(slot);
  assign slot_x    = XW'(slot_q);
  assign slot_idx  = slot_x[SW-1:0];
  assign head_ok   = free_head < CW'(SLOTS);
  assign fresh_ok  = fresh_count < CW'(SLOTS);
  assign alloc_slot = head_ok ? free_head[SW-1:0] : fresh_count[SW-1:0];
  assign alloc_x    = XW'(alloc_slot);

  // alloc reads the free-list head, every other op the addressed slot
  assign rd_addr = (ght_pkg::op_t'(op) == ght_pkg::OP_ALLOC) ? free_head[SW-1:0]
                                                             : slot_in_x[SW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.capture) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    wr_en            = 1'b0;
    wr_addr          = slot_idx;
    wr_data          = rd_data;
    free_head_next   = free_head;
    fresh_count_next = fresh_count;
    r_status         = ght_pkg::ST_OK;
    r_slot           = '0;
    r_entry          = '0;
    r_valid          = 1'b0;

    unique case (ght_pkg::op_t'(op_q))
      ght_pkg::OP_ALLOC: begin
        if (head_ok || fresh_ok) begin
          wr_en       = 1'b1;
          wr_addr     = alloc_slot;
          wr_data.gen = head_ok ? rd_data.gen : '0;
          wr_data.act = 1'b1;
          wr_data.ty  = type_q;
          wr_data.idx = uidx_q;
          if (head_ok) begin
            free_head_next = (rd_data.idx < 32'(SLOTS)) ? CW'(rd_data.idx) : '1;
          end else begin
            fresh_count_next = fresh_count + 1'b1;
          end
          r_slot  = alloc_x[ght_pkg::SLOT_W-1:0];
          r_entry = wr_data;
          r_valid = 1'b1;
        end else begin
          r_status = ght_pkg::ST_FULL;
        end
      end
      ght_pkg::OP_FREE, ght_pkg::OP_QUERY, ght_pkg::OP_ACT,
      ght_pkg::OP_DEACT, ght_pkg::OP_SET_IDX: begin
        r_slot = slot_q;
        if (slot_x >= XW'(SLOTS) || slot_x >= XW'(fresh_count)) begin
          r_status = ght_pkg::ST_NEVER;
        end else if (ght_pkg::op_t'(op_q) == ght_pkg::OP_QUERY) begin
          r_entry = rd_data;
          r_valid = (rd_data.gen == gen_q) && (rd_data.ty == type_q);
        end else if (ght_pkg::op_t'(op_q) == ght_pkg::OP_FREE) begin
          // no generation check on free; old head becomes the link
          wr_en          = 1'b1;
          wr_data.gen    = rd_data.gen + 1'b1;
          wr_data.idx    = head_ok ? 32'(free_head) : ght_pkg::LINK_END;
          free_head_next = CW'(slot_idx);
          r_entry        = wr_data;
          r_valid        = (wr_data.gen == gen_q) && (wr_data.ty == type_q);
        end else if (rd_data.gen != gen_q) begin
          r_status = ght_pkg::ST_STALE;
          r_entry  = rd_data;
        end else begin
          wr_en = 1'b1;
          priority if (ght_pkg::op_t'(op_q) == ght_pkg::OP_ACT) begin
            wr_data.act = 1'b1;
          end else if (ght_pkg::op_t'(op_q) == ght_pkg::OP_DEACT) begin
            wr_data.act = 1'b0;
          end else begin
            wr_data.idx = uidx_q;
          end
          r_entry = wr_data;
          r_valid = (wr_data.ty == type_q);
        end
      end
      default: begin
        r_status = ght_pkg::ST_OK;
      end
    endcase

    if (!cmd.exec) begin
      wr_en            = 1'b0;
      free_head_next   = free_head;
      fresh_count_next = fresh_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head   <= '1;
      fresh_count <= '0;
    end else begin
      free_head   <= free_head_next;
      fresh_count <= fresh_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op;
      slot_q <= slot;
      gen_q  <= generation;
      type_q <= type_tag;
      uidx_q <= entry_index;
    end
    if (cmd.exec) begin
      status         <= r_status;
      slot_out       <= r_slot;
      generation_out <= r_entry.gen;
      type_out       <= r_entry.ty;
      index_out      <= r_entry.idx;
      active_out     <= r_entry.act;
      valid_res      <= r_valid;
    end
  end

endmodule

### sv/generational_handle_table.sv
// Table of SLOTS handles, each with user index, type, active bit and a
// generation that free bumps. Issue an item with start while busy is low;
// each item first does the synchronous read of the entry (the
// free-list head for alloc), then checks, writes the entry back and updates
// the list head. The result is registered and shown for exactly one cycle
// with done high, while the next item may already be accepted. The
// receiver cannot stall results: sample them whenever done is high. The
// table needs no clearing after reset; slots never handed out report
// status 3.
module generational_handle_table #(
  parameter int SLOTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  op,
  input  logic [ght_pkg::SLOT_W-1:0]  slot,
  input  logic [ght_pkg::GEN_W-1:0]   generation,
  input  logic [ght_pkg::TYPE_W-1:0]  type_tag,
  input  logic [ght_pkg::IDX_W-1:0]   entry_index,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [ght_pkg::SLOT_W-1:0]  slot_out,
  output logic [ght_pkg::GEN_W-1:0]   generation_out,
  output logic [ght_pkg::TYPE_W-1:0]  type_out,
  output logic [ght_pkg::IDX_W-1:0]   index_out,
  output logic                        active_out,
  output logic                        valid_res
);

  ght_pkg::cmd_t cmd;

  ght_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  ght_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .op             (op),
    .slot           (slot),
    .generation     (generation),
    .type_tag       (type_tag),
    .entry_index    (entry_index),
    .status         (status),
    .slot_out       (slot_out),
    .generation_out (generation_out),
    .type_out       (type_out),
    .index_out      (index_out),
    .active_out     (active_out),
    .valid_res      (valid_res)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted item did not start work");

  a_one_exec: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy && done)
    else $error("work did not end in one cycle with a result");

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == ght_pkg::ST_FULL |-> slot_out == '0 && !valid_res && !active_out)
    else $error("full result carries data");

  a_stale_invalid: assert property (@(posedge clk) disable iff (rst)
    done && (status == ght_pkg::ST_STALE || status == ght_pkg::ST_NEVER) |-> !valid_res)
    else $error("rejected handle reported valid");

endmodule
